@@ rtl/eqs_pkg.sv @@
// Shared types and constants for the egress queue scheduler.
// No dependencies; imported by every module of the block.
package eqs_pkg;

  localparam int TOTAL_W      = 32;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int SCHED_MODE_W = 2;

  localparam logic [TOTAL_W-1:0] BYTE_LIMIT_RESET = 32'd1048576000;

  typedef enum logic {
    OP_ENQUEUE,
    OP_DEQUEUE
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_LIMIT,
    CFG_SCHED_MODE
  } cfg_reg_t;

  // Encoding 3 is unused and grants nothing.
  typedef enum logic [SCHED_MODE_W-1:0] {
    SCHED_STRICT,
    SCHED_Q0_RR,
    SCHED_TOP2_RR
  } sched_mode_t;

  localparam sched_mode_t SCHED_MODE_RESET = SCHED_TOP2_RR;

endpackage

@@ rtl/eqs_size_ram.sv @@
// Packet size store: one write port, one read port, registered read data.
// Depends on eqs_pkg.
module eqs_size_ram
  import eqs_pkg::*;
#(
  parameter int ADDR_W = 9,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/eqs_arbiter.sv @@
// Dequeue grant selection: strict priority, plus queue-zero-first and top-two
// rules that fall back to a rotated priority encoder. Depends on eqs_pkg.
module eqs_arbiter
  import eqs_pkg::*;
#(
  parameter int NUM_QUEUES = 8
) (
  input  logic                          req,
  input  sched_mode_t                   mode,
  input  logic [NUM_QUEUES-1:0]         nonempty,
  input  logic [NUM_QUEUES-1:0]         paused,
  input  logic [$clog2(NUM_QUEUES)-1:0] rr_last,
  output logic                          grant,
  output logic [$clog2(NUM_QUEUES)-1:0] grant_queue,
  output logic                          move_ptr
);

  localparam int QW = $clog2(NUM_QUEUES);

  logic [NUM_QUEUES-1:0] elig;
  logic [NUM_QUEUES-1:0] elig_above;
  logic [QW-1:0]         strict_q;
  logic [QW-1:0]         rr_q;
  logic                  rr_found;
  logic [QW-1:0]         above_q;
  logic [QW-1:0]         wrap_q;

  assign elig = nonempty & ~paused;

  always_comb begin
    strict_q = '0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      elig_above[i] = elig[i] && (i > int'(rr_last));
      if (elig[i]) begin
        strict_q = QW'(i);
      end
    end
  end

  // lowest eligible queue after the pointer, else lowest overall
  always_comb begin
    above_q = '0;
    wrap_q  = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (elig_above[i]) begin
        above_q = QW'(i);
      end
      if (elig[i]) begin
        wrap_q = QW'(i);
      end
    end
    rr_found = |elig;
    rr_q     = (|elig_above) ? above_q : wrap_q;
  end

  always_comb begin
    grant       = 1'b0;
    grant_queue = '0;
    move_ptr    = 1'b1;
    case (mode)
      SCHED_STRICT: begin
        grant       = |elig;
        grant_queue = strict_q;
      end
      SCHED_Q0_RR: begin
        if (nonempty[0]) begin
          grant       = 1'b1;
          grant_queue = '0;
        end else begin
          grant       = rr_found;
          grant_queue = rr_q;
        end
      end
      SCHED_TOP2_RR: begin
        if (nonempty[NUM_QUEUES-1]) begin
          grant       = 1'b1;
          grant_queue = QW'(NUM_QUEUES - 1);
          move_ptr    = 1'b0;
        end else if (nonempty[NUM_QUEUES-2]) begin
          grant       = 1'b1;
          grant_queue = QW'(NUM_QUEUES - 2);
          move_ptr    = 1'b0;
        end else begin
          grant       = rr_found;
          grant_queue = rr_q;
        end
      end
      default: begin
        grant = 1'b0;
      end
    endcase
    if (!req) begin
      grant       = 1'b0;
      grant_queue = '0;
    end
  end

endmodule

@@ rtl/egress_queue_scheduler_unit.sv @@
// Top level of the egress queue scheduler: queue bookkeeping and pipeline.
// Depends on eqs_pkg, eqs_arbiter and eqs_size_ram.
//
// One word is accepted every cycle while the output is not stalled, and its
// result passes through the input register, the size store read and the
// output register. The per-queue counts, pointers and the running byte total
// are updated in the first stage; the size popped by a dequeue is read from
// the size store in the second stage and taken off the total there, and the
// first stage sees the corrected total through a forward path. A stalled
// output holds the whole pipeline. No clearing pass is needed after reset.
module egress_queue_scheduler_unit
  import eqs_pkg::*;
#(
  parameter int NUM_QUEUES = 8,
  parameter int FIFO_DEPTH = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [$clog2(NUM_QUEUES)-1:0] in_queue_index,
  input  logic [SIZE_BITS-1:0]          in_packet_size,
  input  logic [NUM_QUEUES-1:0]         in_pause_mask,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_enqueue_accepted,
  output logic                          out_grant_valid,
  output logic [$clog2(NUM_QUEUES)-1:0] out_grant_queue,
  output logic [SIZE_BITS-1:0]          out_grant_size,
  output logic [TOTAL_W-1:0]            out_total_bytes,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int AW = QW + PW;
  localparam logic [QW:0]   NQ_CMP   = (QW + 1)'(NUM_QUEUES);
  localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);

  // configuration
  logic [TOTAL_W-1:0] byte_limit_r;
  sched_mode_t        sched_mode_r;

  // queue state
  logic [CW-1:0]      count_r [NUM_QUEUES];
  logic [PW-1:0]      head_r  [NUM_QUEUES];
  logic [PW-1:0]      tail_r  [NUM_QUEUES];
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [QW-1:0]      rr_last_r;
  logic [QW-1:0]      rr_last_nxt;

  // stage 1: input register
  logic                  s1_valid_r;
  op_t                   s1_op_r;
  logic [QW-1:0]         s1_qi_r;
  logic [SIZE_BITS-1:0]  s1_size_r;
  logic [NUM_QUEUES-1:0] s1_mask_r;

  // stage 2: size store read
  logic          s2_valid_r;
  logic          s2_enq_acc_r;
  logic          s2_grant_r;
  logic [QW-1:0] s2_gq_r;

  // output register
  logic                 out_valid_r;
  logic                 out_enq_acc_r;
  logic                 out_gvalid_r;
  logic [QW-1:0]        out_gq_r;
  logic [SIZE_BITS-1:0] out_gsize_r;
  logic [TOTAL_W-1:0]   out_total_r;

  logic                  advance;
  logic [TOTAL_W-1:0]    cur_total;
  logic [TOTAL_W:0]      enq_sum;
  logic                  qi_ok;
  logic                  enq_acc;
  logic                  deq_req;
  logic [NUM_QUEUES-1:0] nonempty;
  logic                  grant;
  logic [QW-1:0]         grant_q;
  logic                  move_ptr;
  logic [SIZE_BITS-1:0]  rd_data;
  logic                  ram_wr_en;
  logic [AW-1:0]         ram_wr_addr;
  logic                  ram_rd_en;
  logic [AW-1:0]         ram_rd_addr;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r <= BYTE_LIMIT_RESET;
      sched_mode_r <= SCHED_MODE_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BYTE_LIMIT: byte_limit_r <= cfg_wdata[TOTAL_W-1:0];
        CFG_SCHED_MODE: sched_mode_r <= sched_mode_t'(cfg_wdata[SCHED_MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // total after the word in stage 2 has popped its size
  assign cur_total = total_r -
                     ((s2_valid_r && s2_grant_r) ? TOTAL_W'(rd_data) : '0);

  assign enq_sum = {1'b0, cur_total} + (TOTAL_W + 1)'(s1_size_r);
  assign qi_ok   = {1'b0, s1_qi_r} < NQ_CMP;
  assign enq_acc = s1_valid_r && (s1_op_r == OP_ENQUEUE) && qi_ok &&
                   (count_r[s1_qi_r] != CNT_FULL) &&
                   (enq_sum < {1'b0, byte_limit_r});
  assign deq_req = s1_valid_r && (s1_op_r == OP_DEQUEUE) && (cur_total != '0);

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      nonempty[i] = count_r[i] != '0;
    end
  end

  eqs_arbiter #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_arbiter (
    .req         (deq_req),
    .mode        (sched_mode_r),
    .nonempty    (nonempty),
    .paused      (s1_mask_r),
    .rr_last     (rr_last_r),
    .grant       (grant),
    .grant_queue (grant_q),
    .move_ptr    (move_ptr)
  );

  assign ram_wr_en   = advance && enq_acc;
  assign ram_wr_addr = {s1_qi_r, tail_r[s1_qi_r]};
  assign ram_rd_en   = advance && grant;
  assign ram_rd_addr = {grant_q, head_r[grant_q]};

  eqs_size_ram #(
    .ADDR_W (AW),
    .DATA_W (SIZE_BITS)
  ) u_size_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (s1_size_r),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (rd_data)
  );

  assign total_nxt   = enq_acc ? enq_sum[TOTAL_W-1:0] : cur_total;
  assign rr_last_nxt = (grant && move_ptr) ? grant_q : rr_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        count_r[i] <= '0;
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
      end
      total_r   <= '0;
      rr_last_r <= '0;
    end else if (advance) begin
      total_r   <= total_nxt;
      rr_last_r <= rr_last_nxt;
      // a word either enqueues or dequeues, never both
      if (enq_acc) begin
        count_r[s1_qi_r] <= count_r[s1_qi_r] + CW'(1);
        tail_r[s1_qi_r]  <= (tail_r[s1_qi_r] == PTR_LAST) ? '0 :
                            tail_r[s1_qi_r] + PW'(1);
      end
      if (grant) begin
        count_r[grant_q] <= count_r[grant_q] - CW'(1);
        head_r[grant_q]  <= (head_r[grant_q] == PTR_LAST) ? '0 :
                            head_r[grant_q] + PW'(1);
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (in_valid) begin
        s1_op_r   <= op_t'(in_op);
        s1_qi_r   <= in_queue_index;
        s1_size_r <= in_packet_size;
        s1_mask_r <= in_pause_mask;
      end
      s2_enq_acc_r  <= enq_acc;
      s2_grant_r    <= grant;
      s2_gq_r       <= grant_q;
      out_enq_acc_r <= s2_enq_acc_r;
      out_gvalid_r  <= s2_grant_r;
      out_gq_r      <= s2_gq_r;
      out_gsize_r   <= s2_grant_r ? rd_data : '0;
      out_total_r   <= cur_total;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_enqueue_accepted = out_enq_acc_r;
  assign out_grant_valid      = out_gvalid_r;
  assign out_grant_queue      = out_gq_r;
  assign out_grant_size       = out_gsize_r;
  assign out_total_bytes      = out_total_r;

endmodule
